// ===== hw/rtl/mrrd_pkg.sv =====
// Shared types, constants and the CRC-16/MODBUS byte update for the reply deframer.
package mrrd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CrcW   = 16;
  localparam int unsigned RangeW = 32;
  localparam int unsigned StatW  = 3;

  localparam logic [ByteW-1:0]  FuncRead   = 8'h03;
  localparam logic [ByteW-1:0]  CountFour  = 8'h04;
  localparam logic [ByteW-1:0]  SlaveIdRst = 8'h01;
  localparam logic [CrcW-1:0]   CrcInit    = 16'hFFFF;
  localparam logic [CrcW-1:0]   CrcPoly    = 16'hA001;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 3'd0,
    ST_ID    = 3'd1,
    ST_FUNC  = 3'd2,
    ST_COUNT = 3'd3,
    ST_CRC   = 3'd4
  } status_e;

  typedef struct packed {
    status_e           status;
    logic [RangeW-1:0] range_mm;
  } res_t;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int k = 0; k < ByteW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/mrrd_in_stage.sv =====
// Input register: captures one received byte per transfer.
module mrrd_in_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [mrrd_pkg::ByteW-1:0] rx_byte_i,
  input  logic                       advance_i,
  output logic                       s1_valid_o,
  output logic [mrrd_pkg::ByteW-1:0] s1_byte_o
);
  import mrrd_pkg::*;

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;

  // Hold while the parser cannot consume the stored byte.
  assign in_stall_o = valid_q & ~advance_i;
  assign valid_d    = in_stall_o ? valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_byte_o  = byte_q;

endmodule

// ===== hw/rtl/mrrd_parser.sv =====
// Frame parser: phase tracking, running CRC, value assembly and slave id register.
module mrrd_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mrrd_pkg::ByteW-1:0] cfg_wdata_i,
  input  logic                       fire_i,
  input  logic [mrrd_pkg::ByteW-1:0] byte_i,
  output logic                       res_valid_o,
  output mrrd_pkg::res_t             res_o
);
  import mrrd_pkg::*;

  typedef enum logic [2:0] {
    PH_ADDR  = 3'd0,
    PH_FUNC  = 3'd1,
    PH_COUNT = 3'd2,
    PH_VALUE = 3'd3,
    PH_CRC   = 3'd4
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [1:0]        idx_q, idx_d;
  logic [CrcW-1:0]   crc_q, crc_d;
  logic [RangeW-1:0] val_q, val_d;
  logic [ByteW-1:0]  crc_lo_q, crc_lo_d;
  logic [ByteW-1:0]  slave_id_q;

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    crc_d       = crc_q;
    val_d       = val_q;
    crc_lo_d    = crc_lo_q;
    res_valid_o = 1'b0;
    res_o       = '{status: ST_OK, range_mm: '0};
    unique case (phase_q)
      PH_FUNC: begin
        if (byte_i != FuncRead) begin
          phase_d      = PH_ADDR;
          idx_d        = '0;
          crc_d        = CrcInit;
          val_d        = '0;
          crc_lo_d     = '0;
          res_valid_o  = 1'b1;
          res_o.status = ST_FUNC;
        end else begin
          crc_d   = crc_byte(crc_q, byte_i);
          phase_d = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (byte_i != CountFour) begin
          phase_d      = PH_ADDR;
          idx_d        = '0;
          crc_d        = CrcInit;
          val_d        = '0;
          crc_lo_d     = '0;
          res_valid_o  = 1'b1;
          res_o.status = ST_COUNT;
        end else begin
          crc_d   = crc_byte(crc_q, byte_i);
          phase_d = PH_VALUE;
          idx_d   = '0;
        end
      end
      PH_VALUE: begin
        crc_d = crc_byte(crc_q, byte_i);
        val_d = {val_q[RangeW-ByteW-1:0], byte_i};
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          phase_d = PH_CRC;
        end
      end
      PH_CRC: begin
        if (idx_q == 2'd0) begin
          crc_lo_d = byte_i;
          idx_d    = 2'd1;
        end else begin
          phase_d     = PH_ADDR;
          idx_d       = '0;
          crc_d       = CrcInit;
          val_d       = '0;
          crc_lo_d    = '0;
          res_valid_o = 1'b1;
          if (crc_lo_q == crc_q[ByteW-1:0] && byte_i == crc_q[CrcW-1:ByteW]) begin
            res_o.status   = ST_OK;
            res_o.range_mm = val_q;
          end else begin
            res_o.status = ST_CRC;
          end
        end
      end
      default: begin
        // Address phase; unused codes restart here too.
        phase_d  = PH_ADDR;
        idx_d    = '0;
        crc_d    = CrcInit;
        val_d    = '0;
        crc_lo_d = '0;
        if (byte_i != slave_id_q) begin
          res_valid_o  = 1'b1;
          res_o.status = ST_ID;
        end else begin
          crc_d   = crc_byte(CrcInit, byte_i);
          phase_d = PH_FUNC;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_ADDR;
      idx_q      <= '0;
      crc_q      <= CrcInit;
      val_q      <= '0;
      crc_lo_q   <= '0;
      slave_id_q <= SlaveIdRst;
    end else begin
      if (fire_i) begin
        phase_q  <= phase_d;
        idx_q    <= idx_d;
        crc_q    <= crc_d;
        val_q    <= val_d;
        crc_lo_q <= crc_lo_d;
      end
      if (cfg_we_i) begin
        slave_id_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ===== hw/rtl/mrrd_out_stage.sv =====
// Result register: holds one status/range result until the receiver takes it.
module mrrd_out_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s1_valid_i,
  input  logic                        res_valid_i,
  input  mrrd_pkg::res_t              res_i,
  output logic                        advance_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mrrd_pkg::StatW-1:0]  status_o,
  output logic [mrrd_pkg::RangeW-1:0] range_mm_o
);
  import mrrd_pkg::*;

  logic valid_q, valid_d;
  logic load;
  res_t res_q;

  // Advance when the slot is empty or its result leaves this cycle.
  assign advance_o = ~valid_q | ~out_stall_i;
  assign load      = advance_o & s1_valid_i & res_valid_i;
  assign valid_d   = advance_o ? (s1_valid_i & res_valid_i) : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign status_o    = StatW'(res_q.status);
  assign range_mm_o  = res_q.range_mm;

endmodule

// ===== hw/rtl/modbus_range_reply_deframer.sv =====
// Top level of the Modbus RTU read-reply deframer.
// Usage:
//   Input channel (in_valid_i / in_stall_o / rx_byte_i) takes one received
//   serial byte per transfer. The block recognizes the 9-byte reply
//   (slave id, 0x03, 0x04, four big-endian value bytes, CRC-16/MODBUS low
//   byte first) and checks the CRC as bytes arrive.
//   Output channel (out_valid_o / out_stall_i / status_o / range_mm_o) gives
//   one result for a finished frame (status 0 with the range, or 4 on a CRC
//   mismatch) and one status result for every rejected header byte.
//   cfg_we_i / cfg_wdata_i write the expected slave id; write only when idle.
// Timing:
//   One byte per cycle sustained unless a result waits under out_stall_i.
//   A byte lands in the input register at its transfer; its result, if any,
//   then lands in the result register when that slot advances, raising
//   out_valid_o. The CRC update feeds the parser's running CRC register.
// Stall and reset:
//   While a result waits under out_stall_i the parser holds and in_stall_o
//   rises once the input register is full. Reset empties both registers,
//   restarts parsing at the address byte and sets the slave id to 1.
module modbus_range_reply_deframer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mrrd_pkg::ByteW-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [mrrd_pkg::ByteW-1:0]  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mrrd_pkg::StatW-1:0]  status_o,
  output logic [mrrd_pkg::RangeW-1:0] range_mm_o
);
  import mrrd_pkg::*;

  logic             advance;
  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             fire;
  logic             res_valid;
  res_t             res;

  assign fire = s1_valid & advance;

  mrrd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .s1_valid_o (s1_valid),
    .s1_byte_o  (s1_byte)
  );

  mrrd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .byte_i      (s1_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mrrd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .res_valid_i (res_valid),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .range_mm_o  (range_mm_o)
  );

endmodule

// ===== sim/tb_modbus_range_reply_deframer.sv =====
// Testbench for the Modbus RTU read-reply deframer: predicted replies vs. DUT results.
`timescale 1ns / 100ps

module tb_modbus_range_reply_deframer;

  localparam int CycleLimit = 300000;
  localparam int DrainCycles = 4;

  typedef enum logic [2:0] {
    WAIT_ADDR,
    WAIT_FUNC,
    WAIT_COUNT,
    TAKE_VALUE,
    TAKE_CRC
  } frm_phase_e;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [mrrd_pkg::ByteW-1:0]   cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [mrrd_pkg::ByteW-1:0]   rx_byte = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [mrrd_pkg::StatW-1:0]   status;
  logic [mrrd_pkg::RangeW-1:0]  range_mm;

  // predictor state
  frm_phase_e                   frm_phase;
  logic [1:0]                   frm_idx;
  logic [mrrd_pkg::CrcW-1:0]    frm_crc;
  logic [mrrd_pkg::RangeW-1:0]  frm_value;
  logic [mrrd_pkg::ByteW-1:0]   frm_crc_lo;
  logic [mrrd_pkg::ByteW-1:0]   exp_slave_id;
  mrrd_pkg::res_t               reply_q[$];

  int  errors = 0;
  int  cycle_cnt = 0;
  int  sent_cnt = 0;
  int  hold_left = 0;
  bit  gap_on = 1'b0;
  bit  stall_on = 1'b0;

  modbus_range_reply_deframer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .range_mm_o  (range_mm)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d replies pending", cycle_cnt, reply_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // Serial form of the reflected CRC-16 (poly 0xA001).
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ mrrd_pkg::CrcPoly;
      end
    end
    return c;
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic frame_restart();
    frm_phase  = WAIT_ADDR;
    frm_idx    = '0;
    frm_crc    = mrrd_pkg::CrcInit;
    frm_value  = '0;
    frm_crc_lo = '0;
  endtask

  // Advance the predicted parser by one accepted byte; queue the reply it causes.
  task automatic deframe_byte(input logic [7:0] b);
    mrrd_pkg::res_t r;
    bit             emit;
    emit       = 1'b0;
    r.status   = mrrd_pkg::ST_OK;
    r.range_mm = '0;
    case (frm_phase)
      WAIT_FUNC: begin
        if (b != mrrd_pkg::FuncRead) begin
          frame_restart();
          emit     = 1'b1;
          r.status = mrrd_pkg::ST_FUNC;
        end else begin
          frm_crc   = crc16_step(frm_crc, b);
          frm_phase = WAIT_COUNT;
        end
      end
      WAIT_COUNT: begin
        if (b != mrrd_pkg::CountFour) begin
          frame_restart();
          emit     = 1'b1;
          r.status = mrrd_pkg::ST_COUNT;
        end else begin
          frm_crc   = crc16_step(frm_crc, b);
          frm_phase = TAKE_VALUE;
          frm_idx   = '0;
        end
      end
      TAKE_VALUE: begin
        frm_crc   = crc16_step(frm_crc, b);
        frm_value = {frm_value[23:0], b};
        if (frm_idx == 2'd3) begin
          frm_idx   = '0;
          frm_phase = TAKE_CRC;
        end else begin
          frm_idx = frm_idx + 2'd1;
        end
      end
      TAKE_CRC: begin
        if (frm_idx == 2'd0) begin
          frm_crc_lo = b;
          frm_idx    = 2'd1;
        end else begin
          emit = 1'b1;
          if (frm_crc_lo == frm_crc[7:0] && b == frm_crc[15:8]) begin
            r.status   = mrrd_pkg::ST_OK;
            r.range_mm = frm_value;
          end else begin
            r.status = mrrd_pkg::ST_CRC;
          end
          frame_restart();
        end
      end
      default: begin
        frame_restart();
        if (b != exp_slave_id) begin
          emit     = 1'b1;
          r.status = mrrd_pkg::ST_ID;
        end else begin
          frm_crc   = crc16_step(mrrd_pkg::CrcInit, b);
          frm_phase = WAIT_FUNC;
        end
      end
    endcase
    if (emit) begin
      reply_q.push_back(r);
    end
  endtask

  task automatic flag_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
    errors++;
  endtask

  // Offer one byte, optionally after an idle gap, and hold it until the transfer.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (gap_on && $urandom_range(0, 99) < 35) ? idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    deframe_byte(b);
    sent_cnt++;
  endtask

  // Drop valid, wait for every pending reply, then let the pipeline settle.
  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_slave_id(input logic [7:0] id);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= id;
    @(negedge clk) cfg_we <= 1'b0;
    exp_slave_id = id;
  endtask

  // Build a reply frame, optionally flip bits in one byte, and send its first n bytes.
  task automatic send_frame(input logic [7:0] id, input logic [31:0] val,
                            input int flip_at, input logic [7:0] flip_mask, input int n);
    logic [7:0]  fb[9];
    logic [15:0] crc;
    fb[0] = id;
    fb[1] = mrrd_pkg::FuncRead;
    fb[2] = mrrd_pkg::CountFour;
    fb[3] = val[31:24];
    fb[4] = val[23:16];
    fb[5] = val[15:8];
    fb[6] = val[7:0];
    crc = mrrd_pkg::CrcInit;
    for (int k = 0; k < 7; k++) begin
      crc = crc16_step(crc, fb[k]);
    end
    fb[7] = crc[7:0];
    fb[8] = crc[15:8];
    if (flip_at >= 0 && flip_at < 9) begin
      fb[flip_at] = fb[flip_at] ^ flip_mask;
    end
    for (int k = 0; k < n; k++) begin
      send_byte(fb[k]);
    end
  endtask

  // Receiver: random stalls, occasional long runs, and a forced hold when asked.
  initial begin
    int run_left;
    run_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (run_left > 0) begin
        out_stall <= 1'b1;
        run_left--;
      end else if (stall_on && $urandom_range(0, 99) < 20) begin
        out_stall <= 1'b1;
        run_left = idle_len() - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each result transfer against the oldest predicted reply.
  always @(posedge clk) begin
    mrrd_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (reply_q.size() == 0) begin
        flag_mismatch("unexpected result, status", 0, status);
      end else begin
        want = reply_q.pop_front();
        if (status !== want.status) begin
          flag_mismatch("status", want.status, status);
        end
        if (range_mm !== want.range_mm) begin
          flag_mismatch("range_mm", want.range_mm, range_mm);
        end
      end
    end
  end

  // Default id, extreme values, and each header reject.
  task automatic test_directed();
    gap_on   = 1'b0;
    stall_on = 1'b0;
    send_frame(exp_slave_id, 32'h0000_0000, -1, 8'h00, 9);
    send_byte(8'hFF);
    send_byte(exp_slave_id);
    send_byte(8'h00);
    send_byte(exp_slave_id);
    send_byte(mrrd_pkg::FuncRead);
    send_byte(8'hFF);
    send_frame(exp_slave_id, 32'hFFFF_FFFF, -1, 8'h00, 9);
    wait_idle();
  endtask

  // Slave id extremes, with CRC low and high byte failures.
  task automatic test_slave_id();
    set_slave_id(8'h00);
    send_frame(8'h00, 32'h1234_5678, -1, 8'h00, 9);
    send_frame(8'h00, 32'h8000_0001, 8, 8'h01, 9);
    send_byte(8'h01);
    wait_idle();
    set_slave_id(8'hFF);
    send_frame(8'hFF, 32'hA5A5_5A5A, -1, 8'h00, 9);
    send_frame(8'hFF, 32'h0F0F_F0F0, 7, 8'h80, 9);
    send_byte(8'h00);
    wait_idle();
  endtask

  // Hold the output long enough that the input stalls while bytes keep coming.
  task automatic test_backpressure();
    gap_on    = 1'b0;
    stall_on  = 1'b0;
    hold_left = 150;
    for (int k = 0; k < 30; k++) begin
      send_byte(exp_slave_id ^ 8'h80 ^ 8'(k));
    end
    send_frame(exp_slave_id, $urandom, -1, 8'h00, 9);
    wait_idle();
  endtask

  // Mostly well-formed frames with random content, plus corrupted, cut and noise bytes.
  task automatic test_random();
    logic [7:0] ids[5];
    int         stop_at;
    int         r;
    ids[0] = 8'(($urandom_range(0, 255)));
    ids[1] = 8'h00;
    ids[2] = 8'hFF;
    ids[3] = 8'(($urandom_range(0, 255)));
    ids[4] = mrrd_pkg::SlaveIdRst;
    for (int p = 0; p < 5; p++) begin
      set_slave_id(ids[p]);
      gap_on   = (p != 0);
      stall_on = (p != 0);
      stop_at  = sent_cnt + 100;
      while (sent_cnt < stop_at) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          send_frame(exp_slave_id, $urandom, -1, 8'h00, 9);
        end else if (r < 77) begin
          send_frame(exp_slave_id, $urandom, $urandom_range(0, 8),
                     8'($urandom_range(1, 255)), 9);
        end else if (r < 87) begin
          send_frame(exp_slave_id, $urandom, -1, 8'h00, $urandom_range(1, 8));
        end else begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
      end
      wait_idle();
    end
  endtask

  initial begin
    exp_slave_id = mrrd_pkg::SlaveIdRst;
    frame_restart();
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_directed();
    test_slave_id();
    test_backpressure();
    test_random();
    wait_idle();
    if (errors == 0 && reply_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
